// ===== rtl/murmurhash2_byte_stream_macros.svh =====
// Assertion macros shared by the hash block RTL.
`ifndef MURMURHASH2_BYTE_STREAM_MACROS_SVH
`define MURMURHASH2_BYTE_STREAM_MACROS_SVH

`ifndef SYNTHESIS
`define MH2BS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MH2BS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MH2BS_ASSERT(label, clk, rst_n, prop, msg)
`define MH2BS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/mh2bs_pkg.sv =====
// Types and constants for the MurmurHash2 byte stream block.
`default_nettype none

package mh2bs_pkg;

  localparam logic [31:0] MH2_MUL     = 32'h5bd1_e995;
  localparam int unsigned MH2_SHIFT   = 24;
  localparam int unsigned MH2_FIN_SH1 = 13;
  localparam int unsigned MH2_FIN_SH2 = 15;

  // One command from the byte gatherer to the mixing engine.
  typedef struct packed {
    logic        start;     // load init into the running hash
    logic [31:0] init;
    logic        mix;       // mix one full word
    logic [31:0] word;
    logic        fin;       // fold tail, final mix, emit
    logic [23:0] tail;
    logic [1:0]  tail_cnt;
    logic        mismatch;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_FIN0,
    S_FIN1,
    S_FIN2
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/mh2bs_front.sv =====
// Front end: takes bytes, gathers words, counts length, issues commands.
`default_nettype none

module mh2bs_front
  import mh2bs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_seed_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] msg_length_i,
  input  wire logic        is_last_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output cmd_t             q_data_o
);

  logic [31:0] seed_q;
  logic [23:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] seen_q, seen_d;
  logic [31:0] decl_q, decl_d;
  logic        in_msg_q, in_msg_d;

  logic        accept;
  logic        first;
  logic        take;
  logic [23:0] pend_base;
  logic [1:0]  cnt_base;
  logic [31:0] seen_base;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign first      = !in_msg_q;
  // empty message: its byte is not data
  assign take       = !(first && (msg_length_i == 32'd0) && is_last_i);
  assign pend_base  = first ? 24'd0 : pend_q;
  assign cnt_base   = first ? 2'd0 : cnt_q;
  assign seen_base  = first ? 32'd0 : seen_q;

  always_comb begin
    pend_d   = pend_base;
    cnt_d    = cnt_base;
    seen_d   = seen_base;
    decl_d   = first ? msg_length_i : decl_q;
    in_msg_d = in_msg_q;
    q_data_o = '0;
    q_data_o.start = first;
    q_data_o.init  = seed_q ^ msg_length_i;
    if (take) begin
      seen_d = seen_base + 32'd1;
      case (cnt_base)
        2'd0: begin
          pend_d = {16'd0, data_byte_i};
          cnt_d  = 2'd1;
        end
        2'd1: begin
          pend_d = {8'd0, data_byte_i, pend_base[7:0]};
          cnt_d  = 2'd2;
        end
        2'd2: begin
          pend_d = {data_byte_i, pend_base[15:0]};
          cnt_d  = 2'd3;
        end
        default: begin
          q_data_o.mix  = 1'b1;
          q_data_o.word = {data_byte_i, pend_base};
          pend_d = 24'd0;
          cnt_d  = 2'd0;
        end
      endcase
    end
    q_data_o.fin      = is_last_i;
    q_data_o.tail     = pend_d;
    q_data_o.tail_cnt = cnt_d;
    q_data_o.mismatch = (seen_d != decl_d);
    if (is_last_i) begin
      in_msg_d = 1'b0;
      pend_d   = 24'd0;
      cnt_d    = 2'd0;
    end else begin
      in_msg_d = 1'b1;
    end
  end

  assign q_push_o = accept && (q_data_o.start || q_data_o.mix || q_data_o.fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= 32'd0;
      pend_q   <= 24'd0;
      cnt_q    <= 2'd0;
      seen_q   <= 32'd0;
      decl_q   <= 32'd0;
      in_msg_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_seed_i;
      end
      if (accept) begin
        pend_q   <= pend_d;
        cnt_q    <= cnt_d;
        seen_q   <= seen_d;
        decl_q   <= decl_d;
        in_msg_q <= in_msg_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mh2bs_queue.sv =====
// Small command queue between the byte gatherer and the mixing engine.
`default_nettype none
`include "murmurhash2_byte_stream_macros.svh"

module mh2bs_queue
  import mh2bs_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == FULL_CNT);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `MH2BS_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `MH2BS_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `MH2BS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FULL_CNT, "queue count overrun")

endmodule

`default_nettype wire

// ===== rtl/mh2bs_back.sv =====
// Back end: word mix and final mix on one shared multiplier, result register.
`default_nettype none
`include "murmurhash2_byte_stream_macros.svh"

module mh2bs_back
  import mh2bs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  wire cmd_t        q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_o,
  output logic             length_mismatch_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] hash_q, hash_d;
  logic        mism_q, mism_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] mul_a;
  logic [31:0] prod;

  assign prod = mul_a * MH2_MUL;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    h_d         = h_q;
    k_d         = k_q;
    hash_d      = hash_q;
    mism_d      = mism_q;
    mul_a       = h_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          if (q_data_i.start) begin
            h_d = q_data_i.init;
          end
          if (q_data_i.mix) begin
            state_d = S_MIX1;
          end else if (q_data_i.fin) begin
            state_d = S_FIN0;
          end
        end
      end
      S_MIX1: begin
        mul_a   = cmd_q.word;
        k_d     = prod;
        state_d = S_MIX2;
      end
      S_MIX2: begin
        mul_a   = k_q ^ (k_q >> MH2_SHIFT);
        k_d     = prod;
        state_d = S_MIX3;
      end
      S_MIX3: begin
        mul_a   = h_q;
        h_d     = prod ^ k_q;
        state_d = cmd_q.fin ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        // tail bytes only fold in when there are any
        mul_a = h_q ^ {8'd0, cmd_q.tail};
        if (cmd_q.tail_cnt != 2'd0) begin
          h_d = prod;
        end
        state_d = S_FIN1;
      end
      S_FIN1: begin
        mul_a   = h_q ^ (h_q >> MH2_FIN_SH1);
        h_d     = prod;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        if (!out_valid_q || !out_stall_i) begin
          hash_d      = h_q ^ (h_q >> MH2_FIN_SH2);
          mism_d      = cmd_q.mismatch;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    h_q    <= h_d;
    k_q    <= k_d;
    hash_q <= hash_d;
    mism_q <= mism_d;
  end

  assign out_valid_o       = out_valid_q;
  assign hash_o            = hash_q;
  assign length_mismatch_o = mism_q;

  `MH2BS_ASSERT(a_mix_order, clk_i, rst_ni, (state_q == S_MIX3) |-> ($past(state_q) == S_MIX2), "word mix out of order")
  `MH2BS_ASSERT(a_out_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == S_FIN2), "result without final mix")
  `MH2BS_ASSERT_NEVER(a_pop_idle, clk_i, rst_ni, q_pop_o && (state_q != S_IDLE), "pop while busy")

endmodule

`default_nettype wire

// ===== rtl/murmurhash2_byte_stream.sv =====
// Result path: with the engine idle, the last byte's command passes the queue, S_IDLE,
// S_MIX1 to S_MIX3 when it completes a word, then S_FIN0 to S_FIN2, before out_valid
// rises; queued commands and output stalls add to it. Throughput: one byte per cycle in
// unless in_stall is high; word mixes in S_MIX1 to S_MIX3 let long messages keep pace.
// Reset: asynchronous, active low; seed clears to 0, block waits for a message start.
`default_nettype none

module murmurhash2_byte_stream
  import mh2bs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_seed_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] msg_length_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_o,
  output logic             length_mismatch_o
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  mh2bs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_seed_i   (cfg_seed_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .msg_length_i (msg_length_i),
    .is_last_i    (is_last_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  mh2bs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  mh2bs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hash_o            (hash_o),
    .length_mismatch_o (length_mismatch_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_murmurhash2_byte_stream.sv =====
// Self-checking testbench for the streaming MurmurHash2 byte hasher.
`default_nettype none

class murmur_scoreboard;
  localparam bit [31:0] MULT = 32'h5bd1_e995;

  typedef struct packed {
    bit [31:0] hash;
    bit        mismatch;
  } hash_result_t;

  bit [31:0]    seed;
  bit [31:0]    running_hash;
  bit [23:0]    tail_bytes;
  bit [1:0]     tail_count;
  bit [31:0]    bytes_seen;
  bit [31:0]    declared_len;
  bit           in_msg;
  hash_result_t pending_hashes[$];
  int           errors;

  function new();
    seed = '0;
    running_hash = '0;
    tail_bytes = '0;
    tail_count = '0;
    bytes_seen = '0;
    declared_len = '0;
    in_msg = 1'b0;
    errors = 0;
  endfunction

  function bit [31:0] word_mix(bit [31:0] h, bit [31:0] k);
    k = k * MULT;
    k = k ^ (k >> 24);
    k = k * MULT;
    h = h * MULT;
    return h ^ k;
  endfunction

  function bit [31:0] final_mix(bit [31:0] h, bit [23:0] tail, bit [1:0] cnt);
    if (cnt != 2'd0) begin
      h = h ^ {8'd0, tail};
      h = h * MULT;
    end
    h = h ^ (h >> 13);
    h = h * MULT;
    h = h ^ (h >> 15);
    return h;
  endfunction

  // Called for every accepted input transfer.
  function void note_byte(bit [7:0] b, bit [31:0] len, bit last);
    bit           take;
    hash_result_t r;
    take = 1'b1;
    if (!in_msg) begin
      declared_len = len;
      running_hash = seed ^ len;
      tail_bytes = '0;
      tail_count = '0;
      bytes_seen = '0;
      in_msg = 1'b1;
      // empty message: byte is not data
      if (len == 32'd0 && last) take = 1'b0;
    end
    if (take) begin
      bytes_seen = bytes_seen + 32'd1;
      if (tail_count == 2'd3) begin
        running_hash = word_mix(running_hash, {b, tail_bytes});
        tail_bytes = '0;
        tail_count = '0;
      end else begin
        tail_bytes = tail_bytes | ({16'd0, b} << (8 * tail_count));
        tail_count = tail_count + 2'd1;
      end
    end
    if (last) begin
      r.hash = final_mix(running_hash, tail_bytes, tail_count);
      r.mismatch = (bytes_seen != declared_len);
      pending_hashes = {pending_hashes, r};
      in_msg = 1'b0;
      tail_bytes = '0;
      tail_count = '0;
    end
  endfunction

  // Called for every accepted output transfer.
  function void check_hash(logic [31:0] h, logic m);
    hash_result_t e;
    if (pending_hashes.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual hash %h mismatch %b",
               $time, h, m);
      errors++;
      return;
    end
    e = pending_hashes.pop_front();
    if (h !== e.hash) begin
      $display("%0t: hash wrong: expected %h actual %h", $time, e.hash, h);
      errors++;
    end
    if (m !== e.mismatch) begin
      $display("%0t: length_mismatch wrong: expected %b actual %b", $time, e.mismatch, m);
      errors++;
    end
  endfunction

  function int pending();
    return pending_hashes.size();
  endfunction

  function void report_leftover();
    while (pending_hashes.size() > 0) begin
      $display("%0t: missing result: expected hash %h mismatch %b, actual none",
               $time, pending_hashes[0].hash, pending_hashes[0].mismatch);
      void'(pending_hashes.pop_front());
      errors++;
    end
  endfunction
endclass

module tb_murmurhash2_byte_stream;

  localparam int  HOLD_CYCLES  = 80;
  localparam int  SETTLE       = 12;
  localparam int  DRAIN_LIMIT  = 5000;
  localparam longint TIMEOUT   = 64'd8_000_000;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_seed_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic [31:0] msg_length_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] hash_o;
  logic        length_mismatch_o;

  murmur_scoreboard sb = new();
  int items_sent = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  murmurhash2_byte_stream DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_seed_i        (cfg_seed_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .msg_length_i      (msg_length_i),
    .is_last_i         (is_last_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hash_o            (hash_o),
    .length_mismatch_o (length_mismatch_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit [7:0] fill_byte(fill_e mode);
    case (mode)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hff;
      default:   return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input bit [7:0] b, input bit [31:0] len, input bit last);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    msg_length_i <= len;
    is_last_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b, len, last);
    items_sent++;
  endtask

  // Length field is only sampled on the first byte; later bytes carry noise there.
  task automatic send_msg(input bit [31:0] declared, input int nbytes, input fill_e mode);
    for (int i = 0; i < nbytes; i++) begin
      send_item(fill_byte(mode), (i == 0) ? declared : $urandom, i == nbytes - 1);
    end
  endtask

  task automatic send_empty();
    send_item(8'($urandom), 32'd0, 1'b1);
  endtask

  task automatic random_message();
    int    pick;
    int    n;
    fill_e mode;
    pick = $urandom_range(0, 9);
    mode = ($urandom_range(0, 7) == 0) ? fill_e'($urandom_range(1, 2)) : FILL_RANDOM;
    if (pick == 0) begin
      send_empty();
    end else if (pick == 1) begin
      // arbitrary declared length, almost always wrong
      n = $urandom_range(1, 9);
      send_msg($urandom, n, mode);
    end else if (pick == 2) begin
      n = $urandom_range(1, 12);
      send_msg($urandom_range(0, 1) ? n + 1 : n - 1, n, mode);
    end else begin
      n = $urandom_range(1, 16);
      send_msg(n, n, mode);
    end
  endtask

  task automatic random_phase(input int target);
    while (items_sent < target) random_message();
  endtask

  // Stop offering and wait for every outstanding hash, then let the engine settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && sb.pending() > 0; w++) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_seed(input bit [31:0] s);
    cfg_seed_i <= s;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.seed = s;
  endtask

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_hash(hash_o, length_mismatch_o);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (no_idle && !hold_req && stall_left > 0 && stall_left <= 7) stall_left = 0;
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_seed_i   <= '0;
    in_valid_i   <= 1'b0;
    data_byte_i  <= '0;
    msg_length_i <= '0;
    is_last_i    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    // directed, reset seed
    send_empty();
    send_msg(32'd0, 2, FILL_RANDOM);          // zero length declared but not last
    send_msg(32'd1, 1, FILL_ONES);
    send_msg(32'd2, 2, FILL_RANDOM);
    send_msg(32'd3, 3, FILL_ONES);
    send_msg(32'd4, 4, FILL_ZERO);
    send_msg(32'd5, 5, FILL_ONES);
    send_msg(32'hffff_ffff, 2, FILL_RANDOM);  // declared far too long
    send_msg(32'd7, 3, FILL_ZERO);            // short by four
    drain();

    write_seed(32'hffff_ffff);
    send_empty();
    // fill the block while the result side holds off
    hold_req = 1'b1;
    repeat (10) send_msg(32'd1, 1, FILL_RANDOM);
    random_phase(140);
    drain();

    write_seed($urandom);
    random_phase(230);
    drain();

    write_seed(32'd0);
    send_empty();
    random_phase(320);
    drain();

    write_seed($urandom);
    random_phase(390);
    drain();

    write_seed(32'h8000_0001);
    no_idle = 1'b1;
    send_empty();
    random_phase(445);
    drain();

    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/mh2bs_pkg.sv
rtl/mh2bs_front.sv
rtl/mh2bs_queue.sv
rtl/mh2bs_back.sv
rtl/murmurhash2_byte_stream.sv
verif/tb_murmurhash2_byte_stream.sv
